>>> rtl/core/ebhp_pkg.sv
`timescale 1ns / 1ps

package ebhp_pkg;

	localparam int IV_BYTES = 8;
	localparam int QDEPTH   = 4;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_SHORT_IV      = 3'd1;
	localparam logic [2:0] ST_SHORT_COUNT   = 3'd2;
	localparam logic [2:0] ST_SHORT_OFFSETS = 3'd3;
	localparam logic [2:0] ST_DECREASING    = 3'd4;
	localparam logic [2:0] ST_EMPTY_SUB     = 3'd5;

	localparam logic KIND_SUB    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One queue entry: an optional subsample from an offset word and an
	// optional end-of-block record whose final subsample the back end works out.
	typedef struct packed {
		logic                      has_sub;
		logic [31:0]               sub_clear;
		logic [31:0]               sub_cipher;
		logic                      is_end;
		logic [2:0]                trunc;
		logic [2:0]                err;
		logic                      part;
		logic                      odd;
		logic                      enc;
		logic [31:0]               pay;
		logic [31:0]               prev;
		logic [31:0]               held;
		logic [8*IV_BYTES-1:0]     iv;
		logic [10:0]               hdr;
	} ebhp_entry_t;

	typedef struct packed {
		logic        valid;
		ebhp_entry_t entry;
	} ebhp_push_t;

endpackage

>>> rtl/core/ebhp_front.sv
`timescale 1ns / 1ps

module ebhp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,
	input  logic               full,
	output ebhp_pkg::ebhp_push_t push
);
	import ebhp_pkg::*;

	typedef enum logic [2:0] {
		PH_SIGNAL,
		PH_IV,
		PH_COUNT,
		PH_OFFSETS,
		PH_PAYLOAD
	} phase_t;

	phase_t                phase_q, ph_d;
	logic [2:0]            idx_q, idx_d;
	logic [1:0]            flags_q, flags_d;
	logic [8*IV_BYTES-1:0] iv_q, iv_d;
	logic [7:0]            total_q, total_d;
	logic [7:0]            pidx_q, pidx_d;
	logic [31:0]           osh_q, osh_d;
	logic [31:0]           prev_q, prev_d;
	logic [31:0]           held_q, held_d;
	logic [31:0]           pay_q, pay_d;
	logic [2:0]            err_q, err_d;
	logic [10:0]           hdr_q, hdr_d;

	logic        accept;
	logic [31:0] off;
	logic [31:0] off_diff;
	logic        off_lt;
	logic        off_eq;
	logic        sub_v;
	logic [31:0] sub_clr;
	logic [31:0] sub_cip;
	logic [2:0]  trunc;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	assign off      = {osh_q[23:0], s_tdata};
	assign off_lt   = off < prev_q;
	assign off_eq   = off == prev_q;
	assign off_diff = off - prev_q;

	always_comb begin
		ph_d    = phase_q;
		idx_d   = idx_q;
		flags_d = flags_q;
		iv_d    = iv_q;
		total_d = total_q;
		pidx_d  = pidx_q;
		osh_d   = osh_q;
		prev_d  = prev_q;
		held_d  = held_q;
		pay_d   = pay_q;
		err_d   = err_q;
		hdr_d   = hdr_q;
		sub_v   = 1'b0;
		sub_clr = '0;
		sub_cip = '0;
		unique case (phase_q)
			PH_SIGNAL: begin
				flags_d = s_tdata[1:0];
				hdr_d   = 11'd1;
				if (s_tdata[0]) begin
					ph_d  = PH_IV;
					idx_d = '0;
					iv_d  = '0;
				end else begin
					ph_d = PH_PAYLOAD;
				end
			end
			PH_IV: begin
				iv_d  = {iv_q[8*IV_BYTES-9:0], s_tdata};
				hdr_d = hdr_q + 11'd1;
				if (idx_q == 3'(IV_BYTES - 1)) begin
					idx_d = '0;
					ph_d  = (flags_q == 2'b11) ? PH_COUNT : PH_PAYLOAD;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_COUNT: begin
				total_d = s_tdata;
				hdr_d   = hdr_q + 11'd1;
				pidx_d  = '0;
				prev_d  = '0;
				held_d  = '0;
				osh_d   = '0;
				idx_d   = '0;
				ph_d    = (s_tdata != 8'd0) ? PH_OFFSETS : PH_PAYLOAD;
			end
			PH_OFFSETS: begin
				osh_d = off;
				hdr_d = hdr_q + 11'd1;
				if (idx_q == 3'd3) begin
					idx_d = '0;
					// once an offset error is latched, ignore later offsets
					if (err_q == ST_OK) begin
						if (off_lt) begin
							err_d = ST_DECREASING;
						end else begin
							if (pidx_q[0]) begin
								if (held_q == 32'd0 && off_eq) begin
									err_d = ST_EMPTY_SUB;
								end else begin
									sub_v   = 1'b1;
									sub_clr = held_q;
									sub_cip = off_diff;
								end
							end else begin
								held_d = off_diff;
							end
							prev_d = off;
						end
					end
					pidx_d = pidx_q + 8'd1;
					if (pidx_d >= total_q) begin
						ph_d = PH_PAYLOAD;
					end
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				if (pay_q != '1) begin
					pay_d = pay_q + 32'd1;
				end
			end
			default: begin
				ph_d = PH_SIGNAL;
			end
		endcase
	end

	always_comb begin
		unique case (ph_d)
			PH_IV:      trunc = ST_SHORT_IV;
			PH_COUNT:   trunc = ST_SHORT_COUNT;
			PH_OFFSETS: trunc = ST_SHORT_OFFSETS;
			default:    trunc = ST_OK;
		endcase
	end

	always_comb begin
		push.valid            = accept && (sub_v || s_tlast);
		push.entry.has_sub    = sub_v;
		push.entry.sub_clear  = sub_clr;
		push.entry.sub_cipher = sub_cip;
		push.entry.is_end     = s_tlast;
		push.entry.trunc      = trunc;
		push.entry.err        = err_d;
		push.entry.part       = flags_d == 2'b11;
		push.entry.odd        = total_d[0];
		push.entry.enc        = flags_d[0];
		push.entry.pay        = pay_d;
		push.entry.prev       = prev_d;
		push.entry.held       = held_d;
		push.entry.iv         = iv_d;
		push.entry.hdr        = hdr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIGNAL;
			idx_q   <= '0;
			flags_q <= '0;
			iv_q    <= '0;
			total_q <= '0;
			pidx_q  <= '0;
			osh_q   <= '0;
			prev_q  <= '0;
			held_q  <= '0;
			pay_q   <= '0;
			err_q   <= '0;
			hdr_q   <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				// block done: back to waiting for a signal byte
				phase_q <= PH_SIGNAL;
				idx_q   <= '0;
				flags_q <= '0;
				iv_q    <= '0;
				total_q <= '0;
				pidx_q  <= '0;
				osh_q   <= '0;
				prev_q  <= '0;
				held_q  <= '0;
				pay_q   <= '0;
				err_q   <= '0;
				hdr_q   <= '0;
			end else begin
				phase_q <= ph_d;
				idx_q   <= idx_d;
				flags_q <= flags_d;
				iv_q    <= iv_d;
				total_q <= total_d;
				pidx_q  <= pidx_d;
				osh_q   <= osh_d;
				prev_q  <= prev_d;
				held_q  <= held_d;
				pay_q   <= pay_d;
				err_q   <= err_d;
				hdr_q   <= hdr_d;
			end
		end
	end

endmodule

>>> rtl/core/ebhp_queue.sv
`timescale 1ns / 1ps

module ebhp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ebhp_pkg::ebhp_push_t  push,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output ebhp_pkg::ebhp_entry_t head
);
	import ebhp_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	ebhp_entry_t   mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full       = count_q == CW'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !full)
		else $error("push into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

>>> rtl/core/ebhp_back.sv
`timescale 1ns / 1ps

module ebhp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ebhp_pkg::ebhp_entry_t head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [143:0]          m_tdata,   // clear_count, cipher_count, status, encrypted,
	                                         // init_vector, header_bytes, zero pad
	output logic                  m_tuser,   // kind
	output logic                  m_tlast    // final_item
);
	import ebhp_pkg::*;

	logic                  valid_q;
	logic                  kind_q;
	logic [31:0]           clear_q;
	logic [31:0]           cipher_q;
	logic [2:0]            status_q;
	logic                  enc_q;
	logic [8*IV_BYTES-1:0] iv_q;
	logic [10:0]           hdr_q;
	logic                  last_q;
	logic                  second_q;

	logic        load;
	logic        fin_path;
	logic        lt;
	logic [31:0] diff;
	logic        fzero;
	logic        fsub;
	logic [2:0]  st;
	logic        has0;
	logic        two;
	logic        take_status;
	logic [31:0] clr0;
	logic [31:0] cip0;

	// work out the closing subsample and the status of an end record
	assign fin_path = head.is_end && head.trunc == ST_OK && !(head.part && head.pay == 32'd0)
		&& head.err == ST_OK && head.part;
	assign lt       = head.pay < head.prev;
	assign diff     = head.pay - head.prev;
	assign fzero    = (head.pay == head.prev) && (!head.odd || head.held == 32'd0);
	assign fsub     = fin_path && !lt && !fzero;

	always_comb begin
		priority if (head.trunc != ST_OK) begin
			st = head.trunc;
		end else if (head.part && head.pay == 32'd0) begin
			st = ST_SHORT_OFFSETS;
		end else if (fin_path) begin
			st = lt ? ST_DECREASING : (fzero ? ST_EMPTY_SUB : ST_OK);
		end else begin
			st = head.err;
		end
	end

	assign has0 = head.has_sub || fsub;
	assign two  = has0 && head.is_end;
	assign clr0 = head.has_sub ? head.sub_clear : (head.odd ? head.held : diff);
	assign cip0 = head.has_sub ? head.sub_cipher : (head.odd ? diff : 32'd0);

	assign load        = !valid_q || m_tready;
	assign take_status = second_q || !has0;
	assign pop         = head_valid && load && (!two || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
			kind_q   <= KIND_SUB;
			clear_q  <= '0;
			cipher_q <= '0;
			status_q <= ST_OK;
			enc_q    <= 1'b0;
			iv_q     <= '0;
			hdr_q    <= '0;
			last_q   <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				second_q <= two && !second_q;
				if (take_status) begin
					kind_q   <= KIND_STATUS;
					clear_q  <= '0;
					cipher_q <= '0;
					status_q <= st;
					enc_q    <= (st == ST_OK) && head.enc;
					iv_q     <= (st == ST_OK && head.enc) ? head.iv : '0;
					hdr_q    <= (st == ST_OK) ? head.hdr : '0;
					last_q   <= 1'b1;
				end else begin
					kind_q   <= KIND_SUB;
					clear_q  <= clr0;
					cipher_q <= cip0;
					status_q <= ST_OK;
					enc_q    <= 1'b0;
					iv_q     <= '0;
					hdr_q    <= '0;
					last_q   <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, hdr_q, iv_q, enc_q, status_q, cipher_q, clear_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> head_valid && head.is_end)
		else $error("second word pending without an end record");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_SUB |-> (clear_q != 32'd0 || cipher_q != 32'd0))
		else $error("empty subsample sent");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != ST_OK |-> iv_q == '0 && hdr_q == '0 && !enc_q)
		else $error("failed status carries header data");

endmodule

>>> rtl/core/encrypted_block_header_parser.sv
`timescale 1ns / 1ps
// Path: a word taken on s_t* goes into the queue, then is registered in the output stage
// before it shows on m_t*. Throughput: one input byte per cycle unless the queue is full;
// a block end that closes a subsample sends two words, everything else one word, drained
// through the 4-deep queue; input stalls only when that queue is full.
// Reset: asynchronous, active low; parser waits for a signal byte, queue and output empty.

module encrypted_block_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // clear_count, cipher_count, status, encrypted,
	                                // init_vector, header_bytes, zero pad
	output logic         m_tuser,   // kind
	output logic         m_tlast    // final_item
);
	import ebhp_pkg::*;

	ebhp_push_t  push;
	logic        full;
	logic        pop;
	logic        head_valid;
	ebhp_entry_t head;

	ebhp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push)
	);

	ebhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ebhp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
